[src/max_pool_5x5_stride1_pad2_unit_defines.svh]
// Assertion macros for the 5x5 max pooling unit.
// Included by the top level; no other dependencies.
`ifndef MAX_POOL_5X5_STRIDE1_PAD2_UNIT_DEFINES_SVH
`define MAX_POOL_5X5_STRIDE1_PAD2_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MP5_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MP5_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MP5_ASSERT_IMP(lbl, ante, cons, msg)
`define MP5_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[src/mp5_pkg.sv]
// Shared types, constants and float compare for the 5x5 max pooling unit.
// No dependencies.
package mp5_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int PLANE_LIMIT    = 1024;
    localparam int ROWS_KEPT      = 5;
    localparam int CFG_IW         = 2;
    localparam int CFG_DW         = 11;

    localparam logic [31:0] NEG_FLOOR = 32'hFF7F_FFFF;

    localparam logic [CFG_IW-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_PLANE_TOTAL  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic step;
        logic next_out;
    } t_cmd;

    typedef struct packed {
        logic has_out;
        logic tap_last;
        logic run_last;
    } t_status;

    // a > b in float order; NaN in a never wins, b is never NaN
    function automatic logic f_gt(input logic [31:0] a, input logic [31:0] b);
        logic a_nan;
        logic both_zero;
        logic res;
        a_nan     = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
        if (a_nan || both_zero) begin
            res = 1'b0;
        end else if (a[31] != b[31]) begin
            res = b[31];
        end else if (!a[31]) begin
            res = a[30:0] > b[30:0];
        end else begin
            res = a[30:0] < b[30:0];
        end
        return res;
    endfunction

endpackage

[src/mp5_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mp5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 5120
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/mp5_ctrl.sv]
// Controller state machine for the 5x5 max pooling unit.
// Depends on mp5_pkg.
module mp5_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_stall,
    input  mp5_pkg::t_status i_status,
    output mp5_pkg::t_cmd    o_cmd,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output mp5_pkg::t_state  o_state
);

    mp5_pkg::t_state r_state;
    mp5_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mp5_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            mp5_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.has_out) begin
                        n_state = mp5_pkg::S_SCAN;
                    end
                end
            end
            mp5_pkg::S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_status.tap_last) begin
                    n_state = mp5_pkg::S_DRAIN;
                end
            end
            mp5_pkg::S_DRAIN: begin
                n_state = mp5_pkg::S_OUT;
            end
            mp5_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    if (i_status.run_last) begin
                        n_state = mp5_pkg::S_IDLE;
                    end else begin
                        o_cmd.next_out = 1'b1;
                        n_state        = mp5_pkg::S_SCAN;
                    end
                end
            end
            default: begin
                n_state = mp5_pkg::S_IDLE;
            end
        endcase
    end

    assign o_state = r_state;

endmodule

[src/mp5_datapath.sv]
// Datapath: config registers, raster position, line store, window scan.
// Depends on mp5_pkg and mp5_ram.
module mp5_datapath #(
    parameter int MAX_WIDTH  = mp5_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mp5_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [31:0]                 i_pixel_value,
    input  logic                        i_cfg_valid,
    input  logic [mp5_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [mp5_pkg::CFG_DW-1:0]  i_cfg_data,
    input  mp5_pkg::t_cmd               i_cmd,
    output mp5_pkg::t_status            o_status,
    output logic [31:0]                 o_pooled_value,
    output logic [9:0]                  o_out_row,
    output logic [9:0]                  o_out_col,
    output logic                        o_last_in_run,
    output logic                        o_plane_end,
    output logic                        o_tensor_end
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int PW    = $clog2(mp5_pkg::PLANE_LIMIT + 1);
    localparam int QW    = $clog2(mp5_pkg::PLANE_LIMIT);
    localparam int DEPTH = mp5_pkg::ROWS_KEPT << CW;
    localparam int AW    = $clog2(DEPTH);

    logic [mp5_pkg::CFG_DW-1:0] r_frame_width, r_frame_height, r_plane_total;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [2:0]    r_slot;
    logic [QW-1:0] r_plane;

    logic [RW-1:0] r_run_row, r_oy, r_rhi;
    logic [CW-1:0] r_ox, r_chi, r_clo;
    logic [2:0]    r_run_slot;
    logic          r_last_plane;
    logic [2:0]    r_dy, r_dx;
    logic          r_pend;
    logic [31:0]   r_acc;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [PW-1:0] p_eff;
    logic          row_more, col_more, col_wrap, row_wrap, plane_wrap;
    logic [RW+1:0] ty;
    logic [CW+1:0] tx;
    logic [RW-1:0] iy;
    logic [CW-1:0] ix;
    logic          tap_ok;
    logic [2:0]    slot_back;
    logic [2:0]    rd_slot;
    logic          rd_en;
    logic [31:0]   rd_data;

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WW'(1);
        end else if (r_frame_width > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_eff = HW'(1);
        end else if (r_frame_height > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_frame_height);
        end
        if (r_plane_total == '0) begin
            p_eff = PW'(1);
        end else if (r_plane_total > mp5_pkg::PLANE_LIMIT) begin
            p_eff = PW'(mp5_pkg::PLANE_LIMIT);
        end else begin
            p_eff = PW'(r_plane_total);
        end
    end

    assign row_more   = ((HW+1)'(r_row) + (HW+1)'(1)) < (HW+1)'(h_eff);
    assign col_more   = ((WW+1)'(r_col) + (WW+1)'(1)) < (WW+1)'(w_eff);
    assign col_wrap   = !col_more;
    assign row_wrap   = col_wrap && !row_more;
    assign plane_wrap = ((PW+1)'(r_plane) + (PW+1)'(1)) >= (PW+1)'(p_eff);

    assign o_status.has_out = (!row_more || r_row >= RW'(2)) &&
                              (!col_more || r_col >= CW'(2));

    // config and raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= mp5_pkg::CFG_DW'(64);
            r_frame_height <= mp5_pkg::CFG_DW'(64);
            r_plane_total  <= mp5_pkg::CFG_DW'(1);
            r_row          <= '0;
            r_col          <= '0;
            r_slot         <= '0;
            r_plane        <= '0;
        end else if (i_cfg_valid && (i_cfg_index == mp5_pkg::CFG_FRAME_WIDTH ||
                                     i_cfg_index == mp5_pkg::CFG_FRAME_HEIGHT ||
                                     i_cfg_index == mp5_pkg::CFG_PLANE_TOTAL)) begin
            case (i_cfg_index)
                mp5_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                mp5_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                mp5_pkg::CFG_PLANE_TOTAL:  r_plane_total  <= i_cfg_data;
                default: ;
            endcase
            r_row   <= '0;
            r_col   <= '0;
            r_slot  <= '0;
            r_plane <= '0;
        end else if (i_cmd.accept) begin
            if (col_wrap) begin
                r_col <= '0;
                if (row_wrap) begin
                    r_row   <= '0;
                    r_slot  <= '0;
                    r_plane <= plane_wrap ? '0 : r_plane + QW'(1);
                end else begin
                    r_row  <= r_row + RW'(1);
                    r_slot <= (r_slot == 3'd4) ? 3'd0 : r_slot + 3'd1;
                end
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // run of outputs and window scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_run_row    <= r_row;
            r_run_slot   <= r_slot;
            r_last_plane <= (PW'(r_plane) + PW'(1)) == p_eff;
            r_oy         <= (r_row >= RW'(2)) ? r_row - RW'(2) : '0;
            r_ox         <= (r_col >= CW'(2)) ? r_col - CW'(2) : '0;
            r_clo        <= (r_col >= CW'(2)) ? r_col - CW'(2) : '0;
            r_rhi        <= row_more ? r_row - RW'(2) : r_row;
            r_chi        <= col_more ? r_col - CW'(2) : r_col;
        end else if (i_cmd.next_out) begin
            if (r_ox == r_chi) begin
                r_ox <= r_clo;
                r_oy <= r_oy + RW'(1);
            end else begin
                r_ox <= r_ox + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dy   <= '0;
            r_dx   <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= rd_en;
            if (i_cmd.accept || i_cmd.next_out) begin
                r_dy <= '0;
                r_dx <= '0;
            end else if (i_cmd.step) begin
                if (r_dx == 3'd4) begin
                    r_dx <= '0;
                    r_dy <= r_dy + 3'd1;
                end else begin
                    r_dx <= r_dx + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept || i_cmd.next_out) begin
            r_acc <= mp5_pkg::NEG_FLOOR;
        end else if (r_pend && mp5_pkg::f_gt(rd_data, r_acc)) begin
            r_acc <= rd_data;
        end
    end

    assign ty     = (RW+2)'(r_oy) + (RW+2)'(r_dy);
    assign tx     = (CW+2)'(r_ox) + (CW+2)'(r_dx);
    assign tap_ok = (ty >= (RW+2)'(2)) && ((ty - (RW+2)'(2)) < (RW+2)'(h_eff)) &&
                    (tx >= (CW+2)'(2)) && ((tx - (CW+2)'(2)) < (CW+2)'(w_eff));
    assign iy        = RW'(ty - (RW+2)'(2));
    assign ix        = CW'(tx - (CW+2)'(2));
    assign slot_back = 3'(r_run_row - iy);
    assign rd_slot   = (r_run_slot >= slot_back) ? r_run_slot - slot_back :
                                                   r_run_slot + 3'd5 - slot_back;
    assign rd_en     = i_cmd.step && tap_ok;

    mp5_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept),
        .i_waddr (AW'({r_slot, r_col})),
        .i_wdata (i_pixel_value),
        .i_re    (rd_en),
        .i_raddr (AW'({rd_slot, ix})),
        .o_rdata (rd_data)
    );

    assign o_status.tap_last = (r_dy == 3'd4) && (r_dx == 3'd4);
    assign o_status.run_last = (r_oy == r_rhi) && (r_ox == r_chi);

    assign o_pooled_value = r_acc;
    assign o_out_row      = 10'(r_oy);
    assign o_out_col      = 10'(r_ox);
    assign o_last_in_run  = o_status.run_last;
    assign o_plane_end    = ((HW+1)'(r_oy) + (HW+1)'(1) == (HW+1)'(h_eff)) &&
                            ((WW+1)'(r_ox) + (WW+1)'(1) == (WW+1)'(w_eff));
    assign o_tensor_end   = o_plane_end && r_last_plane;

endmodule

[src/max_pool_5x5_stride1_pad2_unit.sv]
// 5x5 max pooling, stride 1, pad 2, over IEEE single pixels in raster order,
// plane after plane. Each result that an input releases reads its 5x5 window
// tap by tap through the single read port of the line store, lands the last
// compare in the drain state and is shown in the output state until taken;
// no new input is taken before its run of results is out. Configuration writes
// restart the tensor position and are taken at any time.
// Depends on mp5_pkg, mp5_ctrl, mp5_datapath and the defines header.
`include "max_pool_5x5_stride1_pad2_unit_defines.svh"
module max_pool_5x5_stride1_pad2_unit #(
    parameter int MAX_WIDTH  = mp5_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mp5_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [31:0]                 i_pixel_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [31:0]                 o_pooled_value,
    output logic [9:0]                  o_out_row,
    output logic [9:0]                  o_out_col,
    output logic                        o_last_in_run,
    output logic                        o_plane_end,
    output logic                        o_tensor_end,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mp5_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [mp5_pkg::CFG_DW-1:0]  i_cfg_data
);

    mp5_pkg::t_cmd    cmd;
    mp5_pkg::t_status status;
    mp5_pkg::t_state  state;

    assign o_cfg_ready = 1'b1;

    mp5_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_state     (state)
    );

    mp5_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pixel_value  (i_pixel_value),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_pooled_value (o_pooled_value),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_last_in_run  (o_last_in_run),
        .o_plane_end    (o_plane_end),
        .o_tensor_end   (o_tensor_end)
    );

    `MP5_ASSERT_IMP(a_no_accept_while_out, o_out_valid, o_in_stall, "input taken during output")
    `MP5_ASSERT_IMP(a_tensor_in_plane, o_out_valid && o_tensor_end, o_plane_end, "tensor end off plane end")
    `MP5_ASSERT_IMP(a_plane_end_last, o_out_valid && o_plane_end, o_last_in_run, "plane end not last in run")
    `MP5_ASSERT_NXT(a_scan_flow, state == mp5_pkg::S_SCAN, state == mp5_pkg::S_SCAN || state == mp5_pkg::S_DRAIN, "scan left early")

endmodule

[tb/mp5_result_check.sv]
// Result checker for the 5x5 max pooling unit: watches the pixel, result and
// register-write channels, predicts every pooled result and compares it.
// Depends on mp5_pkg for the register indexes and the floor constant.
`timescale 1ns / 1ps
module mp5_result_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [31:0] i_pixel_value,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_pooled_value,
    input  logic [9:0]  i_out_row,
    input  logic [9:0]  i_out_col,
    input  logic        i_last_in_run,
    input  logic        i_plane_end,
    input  logic        i_tensor_end,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [mp5_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [mp5_pkg::CFG_DW-1:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);

    typedef struct packed {
        logic [31:0] value;
        logic [9:0]  row;
        logic [9:0]  col;
        logic        last;
        logic        pend;
        logic        tend;
    } pool_result_t;

    logic [31:0]  rows_buf [mp5_pkg::ROWS_KEPT*mp5_pkg::DEF_MAX_WIDTH];
    logic [10:0]  width_reg, height_reg, planes_reg;
    int           cur_row, cur_col, cur_plane;
    pool_result_t pooled_q[$];

    // ordering key: larger key means larger float; both zeros share one key
    function automatic logic [31:0] order_key(input logic [31:0] x);
        if (x[30:0] == 31'd0) return 32'h8000_0000;
        return x[31] ? ~x : {1'b1, x[30:0]};
    endfunction

    function automatic bit beats(input logic [31:0] a, input logic [31:0] b);
        if (a[30:23] == 8'hFF && a[22:0] != 23'd0) return 1'b0;
        return order_key(a) > order_key(b);
    endfunction

    function automatic int eff(input logic [10:0] v, input int top);
        if (v == 0) return 1;
        if (v > top) return top;
        return int'(v);
    endfunction

    function automatic logic [31:0] window_peak(input int oy, input int ox,
                                                 input int h, input int w);
        logic [31:0] best;
        logic [31:0] v;
        best = mp5_pkg::NEG_FLOOR;
        for (int iy = oy - 2; iy <= oy + 2; iy++) begin
            for (int ix = ox - 2; ix <= ox + 2; ix++) begin
                if (iy >= 0 && iy < h && ix >= 0 && ix < w) begin
                    v = rows_buf[(iy % mp5_pkg::ROWS_KEPT)*mp5_pkg::DEF_MAX_WIDTH + ix];
                    if (beats(v, best)) best = v;
                end
            end
        end
        return best;
    endfunction

    task automatic take_pixel(input logic [31:0] px);
        int w, h, p, rlo, rhi, clo, chi;
        bit last_plane;
        pool_result_t res;
        w = eff(width_reg, mp5_pkg::DEF_MAX_WIDTH);
        h = eff(height_reg, mp5_pkg::DEF_MAX_HEIGHT);
        p = eff(planes_reg, mp5_pkg::PLANE_LIMIT);
        last_plane = (cur_plane == p - 1);
        rows_buf[(cur_row % mp5_pkg::ROWS_KEPT)*mp5_pkg::DEF_MAX_WIDTH + cur_col] = px;
        if (cur_row + 1 < h) begin
            rlo = cur_row - 2;
            rhi = cur_row - 2;
        end else begin
            rlo = (cur_row >= 2) ? cur_row - 2 : 0;
            rhi = cur_row;
        end
        if (cur_col + 1 < w) begin
            clo = cur_col - 2;
            chi = cur_col - 2;
        end else begin
            clo = (cur_col >= 2) ? cur_col - 2 : 0;
            chi = cur_col;
        end
        if (rlo >= 0 && clo >= 0) begin
            for (int oy = rlo; oy <= rhi; oy++) begin
                for (int ox = clo; ox <= chi; ox++) begin
                    res.value = window_peak(oy, ox, h, w);
                    res.row   = oy[9:0];
                    res.col   = ox[9:0];
                    res.last  = (oy == rhi && ox == chi);
                    res.pend  = (oy == h - 1 && ox == w - 1);
                    res.tend  = res.pend && last_plane;
                    pooled_q.push_back(res);
                end
            end
        end
        cur_col++;
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= h) begin
                cur_row = 0;
                cur_plane++;
                if (cur_plane >= p) cur_plane = 0;
            end
        end
    endtask

    task automatic check_result();
        pool_result_t exp_r;
        if (pooled_q.size() == 0) begin
            $error("result with nothing expected: row %0d col %0d", i_out_row, i_out_col);
            o_errors++;
            return;
        end
        exp_r = pooled_q.pop_front();
        if (i_pooled_value !== exp_r.value) begin
            $error("pooled_value: expected %h, got %h", exp_r.value, i_pooled_value);
            o_errors++;
        end
        if (i_out_row !== exp_r.row) begin
            $error("out_row: expected %0d, got %0d", exp_r.row, i_out_row);
            o_errors++;
        end
        if (i_out_col !== exp_r.col) begin
            $error("out_col: expected %0d, got %0d", exp_r.col, i_out_col);
            o_errors++;
        end
        if (i_last_in_run !== exp_r.last) begin
            $error("last_in_run: expected %b, got %b", exp_r.last, i_last_in_run);
            o_errors++;
        end
        if (i_plane_end !== exp_r.pend) begin
            $error("plane_end: expected %b, got %b", exp_r.pend, i_plane_end);
            o_errors++;
        end
        if (i_tensor_end !== exp_r.tend) begin
            $error("tensor_end: expected %b, got %b", exp_r.tend, i_tensor_end);
            o_errors++;
        end
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_results = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = 11'd64;
            height_reg = 11'd64;
            planes_reg = 11'd1;
            cur_row    = 0;
            cur_col    = 0;
            cur_plane  = 0;
            pooled_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_result();
                o_results++;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    mp5_pkg::CFG_FRAME_WIDTH:  width_reg  = i_cfg_data;
                    mp5_pkg::CFG_FRAME_HEIGHT: height_reg = i_cfg_data;
                    mp5_pkg::CFG_PLANE_TOTAL:  planes_reg = i_cfg_data;
                    default: ;
                endcase
                if (i_cfg_index == mp5_pkg::CFG_FRAME_WIDTH ||
                    i_cfg_index == mp5_pkg::CFG_FRAME_HEIGHT ||
                    i_cfg_index == mp5_pkg::CFG_PLANE_TOTAL) begin
                    cur_row   = 0;
                    cur_col   = 0;
                    cur_plane = 0;
                end
            end
            if (i_in_valid && !i_in_stall) take_pixel(i_pixel_value);
        end
        o_pending = pooled_q.size();
    end

endmodule

[tb/max_pool_5x5_stride1_pad2_unit_test.sv]
// Top of the 5x5 max pooling testbench: clock, reset, pixel and register
// stimulus with random idling, and the verdict.
// Depends on mp5_pkg, the pooling unit and mp5_result_check.
`timescale 1ns / 1ps
module max_pool_5x5_stride1_pad2_unit_test;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 300;
    localparam int PIXEL_GOAL  = 165;
    localparam logic [mp5_pkg::CFG_IW-1:0] CFG_UNUSED = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_pixel_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_pooled_value;
    logic [9:0]  o_out_row;
    logic [9:0]  o_out_col;
    logic        o_last_in_run;
    logic        o_plane_end;
    logic        o_tensor_end;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [mp5_pkg::CFG_IW-1:0] i_cfg_index;
    logic [mp5_pkg::CFG_DW-1:0] i_cfg_data;

    int errors, pending, results;
    int pixels_sent = 0;
    int cycles = 0;
    bit quiet = 1'b0;

    max_pool_5x5_stride1_pad2_unit DUT (.*);

    mp5_result_check checker_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_pixel_value(i_pixel_value),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_pooled_value(o_pooled_value), .i_out_row(o_out_row), .i_out_col(o_out_col),
        .i_last_in_run(o_last_in_run), .i_plane_end(o_plane_end),
        .i_tensor_end(o_tensor_end),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_pixel_value = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < 21);
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [31:0] pick_pixel();
        logic [31:0] special [12] = '{32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
            32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
            32'h0000_0001, 32'h8000_0001, 32'h3F80_0000, 32'hBF80_0000};
        int sel;
        sel = $urandom_range(9);
        if (sel < 2) return special[$urandom_range(11)];
        if (sel < 5) return {1'($urandom_range(1)), 8'd127 + 8'($urandom_range(6)),
                             23'($urandom)};
        return $urandom;
    endfunction

    task automatic push_pixel(input logic [31:0] v);
        while (!quiet && $urandom_range(99) < 21) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_value <= v;
        do @(posedge i_clk); while (o_in_stall);
        pixels_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mp5_pkg::CFG_IW-1:0] idx, input logic [10:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_frame(input logic [10:0] w, input logic [10:0] h,
                             input logic [10:0] p);
        drain();
        write_reg(mp5_pkg::CFG_PLANE_TOTAL, p);
        write_reg(mp5_pkg::CFG_FRAME_HEIGHT, h);
        write_reg(mp5_pkg::CFG_FRAME_WIDTH, w);
    endtask

    initial begin
        logic [31:0] mixed [25] = '{32'h7FC0_0000, 32'hFF80_0000, 32'h0000_0000,
            32'h8000_0000, 32'hFFFF_FFFF, 32'h3F80_0000, 32'hBF80_0000, 32'h7F7F_FFFF,
            32'hFF7F_FFFF, 32'h0000_0001, 32'h8000_0001, 32'h7F80_0000, 32'h4120_0000,
            32'hC120_0000, 32'h0080_0000, 32'h8080_0000, 32'h3F00_0000, 32'hFF80_0000,
            32'hFF80_0000, 32'hFF80_0000, 32'hFF80_0000, 32'hFF80_0000, 32'h3400_0000,
            32'hB400_0000, 32'h7FFF_FFFF};
        int w, h, p, n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: special values on a 5x5 plane
        set_frame(11'd5, 11'd5, 11'd2);
        foreach (mixed[k]) push_pixel(mixed[k]);
        // floor on an all minus-infinity window, and signed zero order
        set_frame(11'd1, 11'd1, 11'd1);
        push_pixel(32'hFF80_0000);
        set_frame(11'd2, 11'd1, 11'd1);
        push_pixel(32'h8000_0000);
        push_pixel(32'h0000_0000);
        // out-of-range registers: zeros act as one, large values clamp
        set_frame(11'd0, 11'd0, 11'd0);
        push_pixel(32'h4000_0000);
        set_frame(11'd2047, 11'd1, 11'd2047);
        write_reg(CFG_UNUSED, 11'h7FF);
        repeat (12) push_pixel(pick_pixel());
        set_frame(11'd3, 11'd2047, 11'd5);
        repeat (9) push_pixel(pick_pixel());

        // random tensors, mostly complete, some cut short
        while (pixels_sent < PIXEL_GOAL) begin
            w = $urandom_range(1, 7);
            h = $urandom_range(1, 7);
            p = $urandom_range(1, 3);
            set_frame(11'(w), 11'(h), 11'(p));
            quiet = ($urandom_range(5) == 0);
            n = w * h * p;
            if (n > 60) n = w * h;
            if ($urandom_range(4) == 0) n = $urandom_range(1, n);
            for (int k = 0; k < n; k++) begin
                if (k == n / 2 && $urandom_range(3) == 0) drain();
                push_pixel(pick_pixel());
            end
            quiet = 1'b0;
        end

        drain();
        $display("pixels sent: %0d, pooled results checked: %0d", pixels_sent, results);
        $display("covered special floats, clamped registers and random small tensors");
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
